// ----- rtl/bmrs_pkg.sv -----
`default_nettype none
package bmrs_pkg;

  // store geometry
  localparam int unsigned MAX_ROWS          = 32;
  localparam int unsigned MAX_WORDS_PER_ROW = 8;
  localparam int unsigned STORE_DEPTH       = MAX_ROWS * MAX_WORDS_PER_ROW;
  localparam int unsigned ADDR_W            = $clog2(STORE_DEPTH);
  localparam int unsigned WORD_W            = 32;

  // field widths
  localparam int unsigned ROWS_W  = 6;
  localparam int unsigned WORDS_W = 4;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned TOTAL_W = ROWS_W + WORDS_W;

  // register reset values
  localparam logic [ROWS_W-1:0]  ROW_COUNT_RST     = 6'd16;
  localparam logic [WORDS_W-1:0] WORDS_PER_ROW_RST = 4'd4;

  // register indexes
  localparam logic REG_ROW_COUNT     = 1'b0;
  localparam logic REG_WORDS_PER_ROW = 1'b1;

  // action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_SCROLL = 2'd2;

  // scroll direction codes
  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_SPRE  = 6'b000100,
    S_SINIT = 6'b001000,
    S_SRUN  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/bitmap_row_scroll_engine_core.sv -----
`default_nettype none
// A write or an out-of-range access goes from acceptance straight to S_RESP, an in-range
// read passes S_READ first; a scroll does S_SPRE and S_SINIT for each row to fetch its edge
// word, then S_SRUN over its words in the shifter, before S_RESP waits for a free output.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (rst_n, synchronous, active low) clears the sequencer, the output valid and the
// configuration registers (16 rows, 4 words); the bitmap store holds no defined value.
module bitmap_row_scroll_engine_core (
  input  wire                     clk,
  input  wire                     rst_n,
  // configuration write port
  input  wire                     cfg_we,
  input  wire                     cfg_index,
  input  wire [5:0]               cfg_wdata,
  // input stream
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire [47:0]              in_tdata,  // word_index[7:0], word_value[39:8],
                                             // direction[40], shift_bits[46:41], wrap[47]
  input  wire [1:0]               in_tuser,  // action[1:0]
  // result stream
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [31:0]             out_tdata, // read_data[31:0]
  output logic                    out_tuser  // index_error[0]
);
  import bmrs_pkg::*;

  // input fields
  logic [1:0]         in_action;
  logic [ADDR_W-1:0]  in_index;
  logic [WORD_W-1:0]  in_value;
  logic               in_dir;
  logic [SHIFT_W-1:0] in_shift;
  logic               in_wrap;

  assign in_action = in_tuser;
  assign in_index  = in_tdata[7:0];
  assign in_value  = in_tdata[39:8];
  assign in_dir    = in_tdata[40];
  assign in_shift  = in_tdata[46:41];
  assign in_wrap   = in_tdata[47];

  // registers
  state_t             state_r, state_nxt;
  logic [ROWS_W-1:0]  row_count_r;
  logic [WORDS_W-1:0] words_per_row_r;
  logic [WORD_W-1:0]  res_data_r, res_data_nxt;
  logic               res_err_r, res_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_data_r, out_data_nxt;
  logic               out_err_r, out_err_nxt;
  logic               dir_r, dir_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               wrap_r, wrap_nxt;
  logic [ROWS_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [WORDS_W-1:0] wk_r, wk_nxt;
  logic [WORD_W-1:0]  prev_r, prev_nxt;

  // store ports
  logic [WORD_W-1:0]  mem [STORE_DEPTH];
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata, mem_q;

  // clamped geometry
  logic [ROWS_W-1:0]  rows_used;
  logic [WORDS_W-1:0] words_used;
  logic [TOTAL_W-1:0] total;
  logic               in_range;
  logic               accept;
  logic               out_free;
  logic [SHIFT_W-1:0] in_shift_clamped;

  assign rows_used  = (row_count_r > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : row_count_r;
  assign words_used = (words_per_row_r > WORDS_W'(MAX_WORDS_PER_ROW)) ?
                      WORDS_W'(MAX_WORDS_PER_ROW) : words_per_row_r;
  assign total      = {{WORDS_W{1'b0}}, rows_used} * {{ROWS_W{1'b0}}, words_used};
  assign in_range   = {{(TOTAL_W-ADDR_W){1'b0}}, in_index} < total;
  assign in_shift_clamped = (in_shift > SHIFT_W'(WORD_W)) ? SHIFT_W'(WORD_W) : in_shift;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // word position inside the row for a given step of the sweep
  function automatic logic [WORDS_W-1:0] word_pos(input logic dir, input logic [WORDS_W-1:0] k,
                                                  input logic [WORDS_W-1:0] words);
    word_pos = (dir == DIR_RIGHT) ? (words - WORDS_W'(1) - k) : k;
  endfunction

  // shared funnel shifter: old word with its neighbor from the sweep
  logic [2*WORD_W-1:0] fun_cat, fun_out;
  logic [SHIFT_W-1:0]  fun_amt;
  logic [WORD_W-1:0]   fun_res;

  always_comb begin
    if (dir_r == DIR_RIGHT) begin
      fun_cat = {prev_r, mem_q};
      fun_amt = shift_r;
    end else begin
      fun_cat = {mem_q, prev_r};
      fun_amt = SHIFT_W'(WORD_W) - shift_r;
    end
    fun_out = fun_cat >> fun_amt;
    fun_res = fun_out[WORD_W-1:0];
  end

  // sequencer
  logic [WORDS_W-1:0] last_w;
  assign last_w = words_used - WORDS_W'(1);

  always_comb begin
    state_nxt     = state_r;
    res_data_nxt  = res_data_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    dir_nxt       = dir_r;
    shift_nxt     = shift_r;
    wrap_nxt      = wrap_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    wk_nxt        = wk_r;
    prev_nxt      = prev_r;
    mem_we        = 1'b0;
    mem_waddr     = in_index;
    mem_wdata     = in_value;
    mem_re        = 1'b0;
    mem_raddr     = in_index;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_data_nxt = '0;
          res_err_nxt  = 1'b0;
          state_nxt    = S_RESP;
          case (in_action)
            ACT_WRITE: begin
              res_err_nxt = !in_range;
              mem_we      = in_range;
            end
            ACT_READ: begin
              res_err_nxt = !in_range;
              mem_re      = in_range;
              if (in_range) begin
                state_nxt = S_READ;
              end
            end
            ACT_SCROLL: begin
              dir_nxt   = in_dir;
              shift_nxt = in_shift_clamped;
              wrap_nxt  = in_wrap;
              row_nxt   = '0;
              base_nxt  = '0;
              if (words_used != '0 && in_shift_clamped != '0 && rows_used != '0) begin
                state_nxt = S_SPRE;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_READ: begin
        res_data_nxt = mem_q;
        state_nxt    = S_RESP;
      end
      S_SPRE: begin
        // edge word that feeds the first step when wrapping
        mem_re    = 1'b1;
        mem_raddr = base_r + ADDR_W'((dir_r == DIR_RIGHT) ? '0 : last_w);
        state_nxt = S_SINIT;
      end
      S_SINIT: begin
        prev_nxt  = wrap_r ? mem_q : '0;
        mem_re    = 1'b1;
        mem_raddr = base_r + ADDR_W'(word_pos(dir_r, '0, words_used));
        wk_nxt    = '0;
        state_nxt = S_SRUN;
      end
      S_SRUN: begin
        // write the shifted word and fetch the next one in sweep order
        mem_we    = 1'b1;
        mem_waddr = base_r + ADDR_W'(word_pos(dir_r, wk_r, words_used));
        mem_wdata = fun_res;
        prev_nxt  = mem_q;
        wk_nxt    = wk_r + WORDS_W'(1);
        if (wk_r != last_w) begin
          mem_re    = 1'b1;
          mem_raddr = base_r + ADDR_W'(word_pos(dir_r, wk_r + WORDS_W'(1), words_used));
        end else if (row_r + ROWS_W'(1) < rows_used) begin
          row_nxt   = row_r + ROWS_W'(1);
          base_nxt  = base_r + ADDR_W'(words_used);
          state_nxt = S_SPRE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      row_count_r     <= ROW_COUNT_RST;
      words_per_row_r <= WORDS_PER_ROW_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT:     row_count_r     <= cfg_wdata;
          REG_WORDS_PER_ROW: words_per_row_r <= cfg_wdata[WORDS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
    res_err_r  <= res_err_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
    dir_r      <= dir_nxt;
    shift_r    <= shift_nxt;
    wrap_r     <= wrap_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    wk_r       <= wk_nxt;
    prev_r     <= prev_nxt;
  end

  // bitmap store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire
